// ===== rtl/seven_segment_595_scanner_assert.svh =====
// Assertion helpers for the display scanner.
// Each macro expects clk_i and rst_ni in scope.
`ifndef SEVEN_SEGMENT_595_SCANNER_ASSERT_SVH
`define SEVEN_SEGMENT_595_SCANNER_ASSERT_SVH

// Same-cycle implication.
`define SSS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sss_pkg.sv =====
package sss_pkg;

  localparam int VALUE_W         = 14;
  localparam int POS_W           = 3;
  localparam int BIT_NUM_W       = 4;
  localparam int DIGIT_COUNT_DEF = 4;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [VALUE_W-1:0]   VALUE_MAX = 14'd9999;
  localparam logic [BIT_NUM_W-1:0] LAST_BIT  = 4'd15;

  // One frame as it goes out on the wire: select byte first, MSB first.
  typedef struct packed {
    logic [7:0] sel;
    logic [7:0] seg;
  } frame_t;

  // Active-low segment pattern for a decimal digit.
  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'hc0;
      4'd1:    code = 8'hf9;
      4'd2:    code = 8'ha4;
      4'd3:    code = 8'hb0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hf8;
      4'd8:    code = 8'h80;
      default: code = 8'h90;
    endcase
    return code;
  endfunction

endpackage

// ===== rtl/sss_front.sv =====
module sss_front #(
  parameter int DIGIT_COUNT = sss_pkg::DIGIT_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sss_pkg::VALUE_W-1:0]  in_value_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output sss_pkg::frame_t              push_data_o
);
  import sss_pkg::*;

  logic [POS_W-1:0]    pos_q, pos_d;
  logic [POS_W:0]      pos_inc;
  logic [VALUE_W-1:0]  sat_value;
  logic [13:0]         recip;
  logic [4:0]          shift_amt;
  logic                blank;
  logic [27:0]         prod;
  logic [VALUE_W-1:0]  quot;

  logic                s1_valid_q;
  logic [VALUE_W-1:0]  s1_quot_q;
  logic [POS_W-1:0]    s1_pos_q;

  logic [30:0]         tens_prod;
  logic [VALUE_W-1:0]  tens;
  logic [VALUE_W-1:0]  rem;
  logic                accept;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !s1_valid_q || push_ready_i;

  assign pos_inc = {1'b0, pos_q} + {{POS_W{1'b0}}, 1'b1};
  assign pos_d   = (pos_inc >= (POS_W+1)'(DIGIT_COUNT)) ? '0 : pos_inc[POS_W-1:0];

  assign sat_value = (in_value_i > VALUE_MAX) ? VALUE_MAX : in_value_i;

  // Divide by 1000, 100, 10 or 1 through a scaled reciprocal; positions past the fourth give zero.
  always_comb begin
    recip     = 14'd0;
    shift_amt = 5'd0;
    blank     = 1'b0;
    case (pos_q)
      3'd0: begin
        recip     = 14'd8389;
        shift_amt = 5'd23;
      end
      3'd1: begin
        recip     = 14'd10486;
        shift_amt = 5'd20;
      end
      3'd2: begin
        recip     = 14'd6554;
        shift_amt = 5'd16;
      end
      3'd3: begin
        recip     = 14'd1;
        shift_amt = 5'd0;
      end
      default: blank = 1'b1;
    endcase
  end

  assign prod = 28'(sat_value) * 28'(recip);
  assign quot = blank ? '0 : VALUE_W'(prod >> shift_amt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        pos_q      <= pos_d;
        s1_valid_q <= 1'b1;
      end else if (push_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_quot_q <= quot;
      s1_pos_q  <= pos_q;
    end
  end

  // Keep the last decimal digit of the quotient.
  assign tens_prod = 31'(s1_quot_q) * 31'd6554;
  assign tens      = VALUE_W'(tens_prod >> 16);
  assign rem       = s1_quot_q - VALUE_W'({tens, 3'b000}) - VALUE_W'({tens, 1'b0});

  assign push_valid_o    = s1_valid_q;
  assign push_data_o.sel = 8'(8'd1 << s1_pos_q);
  assign push_data_o.seg = seg_code(rem[3:0]);

endmodule

// ===== rtl/sss_queue.sv =====
module sss_queue #(
  parameter int DEPTH = sss_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  sss_pkg::frame_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output sss_pkg::frame_t pop_data_o
);
  import sss_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  frame_t             mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]   count_q;
  logic               push, pop;

  assign push_ready_o = (count_q != CNT_W'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== rtl/sss_back.sv =====
module sss_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  sss_pkg::frame_t               pop_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_bit_o,
  output logic [sss_pkg::BIT_NUM_W-1:0] out_bit_num_o,
  output logic                          out_last_o
);
  import sss_pkg::*;

  logic                 valid_q;
  logic [15:0]          shift_q;
  logic [BIT_NUM_W-1:0] cnt_q;
  logic                 last;
  logic                 load;

  assign last        = (cnt_q == LAST_BIT);
  assign pop_ready_o = !valid_q || (out_ready_i && last);
  assign load        = pop_valid_i && pop_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        cnt_q   <= '0;
      end else if (valid_q && out_ready_i) begin
        if (last) begin
          valid_q <= 1'b0;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end
    end
  end

  // Load a new frame, or advance one bit per taken beat.
  always_ff @(posedge clk_i) begin
    if (load) begin
      shift_q <= pop_data_i;
    end else if (valid_q && out_ready_i) begin
      shift_q <= {shift_q[14:0], 1'b0};
    end
  end

  assign out_valid_o   = valid_q;
  assign out_bit_o     = shift_q[15];
  assign out_bit_num_o = cnt_q;
  assign out_last_o    = last;

endmodule

// ===== rtl/seven_segment_595_scanner.sv =====
// Seven-segment scanner for a display behind two cascaded 74HC595 shift registers.
// Slave stream: one beat per refresh tick; tdata[13:0] is the value to show
// (values above 9999 show as 9999). Each tick shows one digit position, thousands
// first, and the position advances and wraps at DIGIT_COUNT; positions past the
// fourth show zero. Reset returns the position to the thousands digit.
// Master stream: 16 beats per tick, one serial data bit each, select byte then
// segment byte, MSB first. tdata[0] is the data line level, tdata[4:1] the bit
// number in the frame; tlast marks the last bit, after which the latch is pulsed.
// The first bit of a frame passes through the front decode register, the queue
// entry, then the output shift register before it leaves.
// The output shifter sends one bit per beat; a frame already queued follows the
// last bit of the one before with no gap cycle. A two-entry queue
// sits between the digit decode and the shifter, so ticks are taken while a
// frame is still shifting; when the receiver stalls, the shifter holds its bit,
// the queue fills and then tready falls until the shifter takes the next frame.
`include "seven_segment_595_scanner_assert.svh"

module seven_segment_595_scanner #(
  parameter int DIGIT_COUNT = sss_pkg::DIGIT_COUNT_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [13:0] value, [15:14] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [0] serial_bit, [4:1] bit_number, [7:5] zero
  output logic        m_axis_tlast_o    // latch_now
);
  import sss_pkg::*;

  logic                 push_valid, push_ready;
  frame_t               push_data;
  logic                 pop_valid, pop_ready;
  frame_t               pop_data;
  logic                 out_bit;
  logic [BIT_NUM_W-1:0] out_bit_num;

  sss_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_value_i  (s_axis_tdata_i[VALUE_W-1:0]),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  sss_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  sss_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pop_valid_i  (pop_valid),
    .pop_ready_o  (pop_ready),
    .pop_data_i   (pop_data),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_bit_o    (out_bit),
    .out_bit_num_o(out_bit_num),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, out_bit_num, out_bit};

  `SSS_ASSERT_NEXT(a_frame_continues, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, m_axis_tvalid_o && (out_bit_num == 4'($past(out_bit_num) + 4'd1)), "frame broke off before its last bit")
  `SSS_ASSERT_NEXT(a_front_holds, push_valid && !push_ready, push_valid, "decoded frame dropped while queue full")
  `SSS_ASSERT_IMPLY(a_stall_cause, !s_axis_tready_o, push_valid && !push_ready, "input stalled without a full queue")

endmodule

// ===== bench/tb_seven_segment_595_scanner.sv =====
module tb_seven_segment_595_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  import sss_pkg::frame_t;
  import sss_pkg::VALUE_MAX;
  import sss_pkg::LAST_BIT;

  localparam int DIGITS      = sss_pkg::DIGIT_COUNT_DEF;
  localparam int RANDOM_TICKS = 360;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;

  localparam logic [7:0] SEG_PATTERN [10] = '{
    8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
  };

  typedef struct {
    logic       serial_bit;
    logic [3:0] bit_number;
    logic       latch_now;
  } shift_bit_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;    // [13:0] value, [15:14] zero
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;    // [0] serial_bit, [4:1] bit_number, [7:5] zero
  logic        m_axis_tlast;    // latch_now

  logic [13:0] ticks_pending[$];
  shift_bit_t  shift_bits_due[$];
  shift_bit_t  due_bit;
  int          shown_pos;
  int          send_wait;
  int          send_calm;
  int          recv_wait;
  int          recv_calm;
  int          recv_draw;
  int          errors;
  int          cycle_count;

  seven_segment_595_scanner #(
    .DIGIT_COUNT(DIGITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly a random idle wait between beats, with occasional runs of back-to-back beats.
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 5);
  endfunction

  function automatic frame_t frame_for(logic [13:0] raw, int pos);
    int     shown;
    int     digit;
    frame_t f;
    shown = (raw > VALUE_MAX) ? int'(VALUE_MAX) : int'(raw);
    case (pos)
      0:       digit = shown / 1000;
      1:       digit = (shown / 100) % 10;
      2:       digit = (shown / 10) % 10;
      3:       digit = shown % 10;
      default: digit = 0;
    endcase
    f.sel = 8'(1 << pos);
    f.seg = SEG_PATTERN[digit];
    return f;
  endfunction

  // Queue the 16 serial bits of one refresh tick, then advance the digit.
  task automatic predict_tick(logic [13:0] raw);
    logic [15:0] frame;
    shift_bit_t  sb;
    frame = frame_for(raw, shown_pos);
    for (int k = 0; k < 16; k++) begin
      sb.serial_bit = frame[15-k];
      sb.bit_number = 4'(k);
      sb.latch_now  = (4'(k) == LAST_BIT);
      shift_bits_due.push_back(sb);
    end
    shown_pos = (shown_pos + 1 >= DIGITS) ? 0 : shown_pos + 1;
  endtask

  // Tick driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_wait     <= 0;
      shown_pos     = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_tick(s_axis_tdata[13:0]);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_wait > 0) begin
          s_axis_tvalid <= 1'b0;
          send_wait     <= send_wait - 1;
        end else if (ticks_pending.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, ticks_pending.pop_front()};
          send_wait     <= pick_wait(send_calm);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Serial bit monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (shift_bits_due.size() == 0) begin
          $error("unexpected beat: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
          errors++;
        end else begin
          due_bit = shift_bits_due.pop_front();
          if (m_axis_tdata[0] !== due_bit.serial_bit) begin
            $error("serial_bit: expected %0d, got %0d", due_bit.serial_bit, m_axis_tdata[0]);
            errors++;
          end
          if (m_axis_tdata[4:1] !== due_bit.bit_number) begin
            $error("bit_number: expected %0d, got %0d", due_bit.bit_number,
                   m_axis_tdata[4:1]);
            errors++;
          end
          if (m_axis_tlast !== due_bit.latch_now) begin
            $error("latch_now: expected %0d, got %0d", due_bit.latch_now, m_axis_tlast);
            errors++;
          end
          if (m_axis_tdata[7:5] !== 3'b000) begin
            $error("tdata pad: expected 0, got %0d", m_axis_tdata[7:5]);
            errors++;
          end
        end
        recv_draw = pick_wait(recv_calm);
        m_axis_tready <= (recv_draw == 0);
        recv_wait     <= recv_draw;
      end else if (!m_axis_tready) begin
        if (recv_wait <= 1) begin
          m_axis_tready <= 1'b1;
        end
        recv_wait <= recv_wait - 1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [13:0] held [6];
    int          r;
    errors      = 0;
    cycle_count = 0;
    send_calm   = 0;
    recv_calm   = 0;
    rst_ni      = 1'b0;

    // Each value held for a full scan: every position shows it, including
    // saturation of out-of-range values and the all-zero and all-one extremes.
    held = '{14'd1234, 14'd5678, 14'd9012, 14'd16383, 14'd0, 14'd10000};
    foreach (held[i]) begin
      repeat (DIGITS) ticks_pending.push_back(held[i]);
    end
    ticks_pending.push_back(14'd9999);
    for (int i = 0; i < RANDOM_TICKS; i++) begin
      r = $urandom_range(0, 9);
      if (r < 7) begin
        ticks_pending.push_back(14'($urandom_range(0, 9999)));
      end else if (r < 9) begin
        ticks_pending.push_back(14'($urandom_range(10000, 16383)));
      end else begin
        ticks_pending.push_back(14'($urandom));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (ticks_pending.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (shift_bits_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
